// ===== src/uqt_pkg.sv =====
// Shared types and constants for the URL query tokenizer.
package uqt_pkg;

  localparam int DEFAULT_MAX_QUERY_LEN = 4096;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  localparam int START_W    = 12;
  localparam int LEN_W      = 13;
  localparam int IN_TDATA_W = 8;
  localparam int TDATA_W    = 56;
  localparam int TUSER_W    = 2;
  localparam int OUT_DEPTH  = 4;

  typedef enum logic [1:0] {
    KIND_KEY       = 2'd0,
    KIND_KEY_VALUE = 2'd1,
    KIND_DONE      = 2'd2
  } token_kind_t;

  typedef enum logic {
    PHASE_KEY   = 1'b0,
    PHASE_VALUE = 1'b1
  } phase_t;

  typedef struct packed {
    token_kind_t         token_kind;
    logic [START_W-1:0]  key_start;
    logic [LEN_W-1:0]    key_len;
    logic [START_W-1:0]  value_start;
    logic [LEN_W-1:0]    value_len;
    logic                overflow;
    logic                last_result;
  } result_t;

endpackage

// ===== src/url_query_tokenizer.sv =====
// Top level of the URL query tokenizer: byte parser and result queue.
//
// The block splits a URI query string into key and key=value tokens. Bytes
// arrive on the s_ channel, one item per byte, with s_tlast marking the final
// byte of the query. Each finished token with a non-empty key leaves on the
// m_ channel as one item carrying the offsets and lengths of its key and
// value; m_tuser gives its kind (key only, key with value, or done). After the
// last byte a done item with m_tlast high closes the query, and the parser
// returns to its initial state so the next byte starts a new query.
//
// A byte is parsed in the cycle it is accepted; its results are written into
// a four-entry output queue and can be taken in the next cycle. The parser takes
// one byte per cycle. A byte can produce up to two items (a token and the done
// item), so s_tready is high while the queue has room for two more; with the
// receiver taking one item per cycle this keeps a steady byte per cycle unless
// bytes keep producing two items each, for example a run of one-byte queries.
// When the receiver stalls, items wait in the queue and s_tready drops once
// fewer than two slots are free. A synchronous reset empties the queue and
// clears the phase, the position, the current token and the overflow flag.
module url_query_tokenizer
  import uqt_pkg::*;
#(
  parameter int MAX_QUERY_LEN = DEFAULT_MAX_QUERY_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,  // [7:0] query_byte
  input  logic                  s_tlast,  // last_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [11:0] key_start, [24:12] key_len, [36:25] value_start,
  // [49:37] value_len, [50] overflow, [55:51] zero
  output logic [TDATA_W-1:0]    m_tdata,
  output logic [TUSER_W-1:0]    m_tuser,  // [1:0] token_kind
  output logic                  m_tlast   // last_result
);

  // The position counts up to MAX_QUERY_LEN itself, and lengths saturate there.
  localparam int POS_W = $clog2(MAX_QUERY_LEN + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_QUERY_LEN);
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(OUT_DEPTH - 2);

  // Parser state.
  phase_t             phase;
  logic [POS_W-1:0]   position;
  logic [START_W-1:0] cur_key_start;
  logic [POS_W-1:0]   cur_key_len;
  logic [START_W-1:0] cur_value_start;
  logic [POS_W-1:0]   cur_value_len;
  logic               overflowed;

  phase_t             phase_next;
  logic [POS_W-1:0]   position_next;
  logic [START_W-1:0] cur_key_start_next;
  logic [POS_W-1:0]   cur_key_len_next;
  logic [START_W-1:0] cur_value_start_next;
  logic [POS_W-1:0]   cur_value_len_next;
  logic               overflowed_next;

  // State after the byte itself, before the end of the query is handled.
  phase_t             aft_phase;
  logic [START_W-1:0] aft_key_start;
  logic [POS_W-1:0]   aft_key_len;
  logic [START_W-1:0] aft_value_start;
  logic [POS_W-1:0]   aft_value_len;

  logic               is_sep;
  logic               is_eq;
  logic               byte_closes;
  logic               tok_valid;
  result_t            tok;
  result_t            done_item;
  logic [1:0]         push_n;

  // Output queue.
  result_t            queue [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  logic               in_fire;
  logic               out_fire;
  result_t            head;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (count <= READY_LIMIT);
  assign m_tvalid = (count != '0);

  always_comb begin
    is_sep = (s_tdata == CHAR_AMP) || (s_tdata == CHAR_SEMI) || (s_tdata == CHAR_NUL);
    is_eq  = (s_tdata == CHAR_EQ);

    // Once the position reaches the limit it freezes and the query is flagged.
    overflowed_next = overflowed || (position >= MAX_POS);
    position_next   = (position >= MAX_POS) ? position : position + 1'b1;

    aft_phase       = phase;
    aft_key_start   = cur_key_start;
    aft_key_len     = cur_key_len;
    aft_value_start = cur_value_start;
    aft_value_len   = cur_value_len;
    byte_closes     = 1'b0;

    if (phase == PHASE_KEY) begin
      if (is_sep) begin
        byte_closes = 1'b1;
      end else if (is_eq) begin
        aft_phase       = PHASE_VALUE;
        aft_value_start = START_W'({1'b0, position} + 1'b1);
        aft_value_len   = '0;
      end else begin
        if (cur_key_len == '0) begin
          aft_key_start = START_W'(position);
        end
        aft_key_len = (cur_key_len < MAX_POS) ? cur_key_len + 1'b1 : cur_key_len;
      end
    end else begin
      // A second '=' ends the value just as a separator does.
      if (is_sep || is_eq) begin
        byte_closes = 1'b1;
      end else begin
        aft_value_len = (cur_value_len < MAX_POS) ? cur_value_len + 1'b1 : cur_value_len;
      end
    end

    if (byte_closes) begin
      aft_phase       = PHASE_KEY;
      aft_key_start   = '0;
      aft_key_len     = '0;
      aft_value_start = '0;
      aft_value_len   = '0;
    end

    // At most one token per byte: either this byte closed the current token,
    // or the end of the query closes what is left after the byte.
    tok = '0;
    tok.overflow = overflowed_next;
    if (byte_closes) begin
      tok_valid     = (cur_key_len != '0);
      tok.key_start = cur_key_start;
      tok.key_len   = LEN_W'(cur_key_len);
      if (phase == PHASE_VALUE) begin
        tok.token_kind  = KIND_KEY_VALUE;
        tok.value_start = cur_value_start;
        tok.value_len   = LEN_W'(cur_value_len);
      end else begin
        tok.token_kind = KIND_KEY;
      end
    end else begin
      tok_valid     = s_tlast && (aft_key_len != '0);
      tok.key_start = aft_key_start;
      tok.key_len   = LEN_W'(aft_key_len);
      if (aft_phase == PHASE_VALUE) begin
        tok.token_kind  = KIND_KEY_VALUE;
        tok.value_start = aft_value_start;
        tok.value_len   = LEN_W'(aft_value_len);
      end else begin
        tok.token_kind = KIND_KEY;
      end
    end

    done_item             = '0;
    done_item.token_kind  = KIND_DONE;
    done_item.overflow    = overflowed_next;
    done_item.last_result = 1'b1;

    push_n = {1'b0, tok_valid} + {1'b0, s_tlast};

    // The end of the query returns the parser to its initial state.
    if (s_tlast) begin
      phase_next           = PHASE_KEY;
      position_next        = '0;
      cur_key_start_next   = '0;
      cur_key_len_next     = '0;
      cur_value_start_next = '0;
      cur_value_len_next   = '0;
      overflowed_next      = 1'b0;
    end else begin
      phase_next           = aft_phase;
      cur_key_start_next   = aft_key_start;
      cur_key_len_next     = aft_key_len;
      cur_value_start_next = aft_value_start;
      cur_value_len_next   = aft_value_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PHASE_KEY;
      position        <= '0;
      cur_key_start   <= '0;
      cur_key_len     <= '0;
      cur_value_start <= '0;
      cur_value_len   <= '0;
      overflowed      <= 1'b0;
    end else if (in_fire) begin
      phase           <= phase_next;
      position        <= position_next;
      cur_key_start   <= cur_key_start_next;
      cur_key_len     <= cur_key_len_next;
      cur_value_start <= cur_value_start_next;
      cur_value_len   <= cur_value_len_next;
      overflowed      <= overflowed_next;
    end
  end

  // Queue storage: the token goes first, the done item right behind it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (tok_valid) begin
        queue[wr_ptr] <= tok;
        if (s_tlast) begin
          queue[wr_ptr + 1'b1] <= done_item;
        end
      end else if (s_tlast) begin
        queue[wr_ptr] <= done_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(push_n);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_fire ? CNT_W'(push_n) : '0) - CNT_W'(out_fire);
    end
  end

  assign head    = queue[rd_ptr];
  assign m_tdata = {5'b0, head.overflow, head.value_len, head.value_start,
                    head.key_len, head.key_start};
  assign m_tuser = head.token_kind;
  assign m_tlast = head.last_result;

endmodule
